@@ hw/rtl/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic [REQ_W-1:0]          req_t;
  typedef logic [STAT_W-1:0]         stat_code_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_REMOVE = 2'd1;
  localparam req_t REQ_SEARCH = 2'd2;

  localparam stat_code_t ST_DONE      = 2'd0;
  localparam stat_code_t ST_NOT_FOUND = 2'd1;
  localparam stat_code_t ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    RD_MID,
    RD_LO,
    RD_SHIFT
  } rd_sel_t;

  typedef struct packed {
    logic       load;
    rd_sel_t    rd_sel;
    logic       step;
    logic       ptr_init;
    logic       wr_shift;
    logic       wr_val;
    logic       dec_count;
    logic       res_load;
    stat_code_t res_status;
    logic       res_pos_lo;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic search_done;
    logic lo_in_range;
    logic match;
    logic shift_end;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/sle_dp.sv @@
`default_nettype none

module sle_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sle_pkg::req_t            req_type,
  input  wire sle_pkg::data_t           value,
  input  wire sle_pkg::cmd_t            cmd,
  output sle_pkg::dp_stat_t             stat,
  output sle_pkg::stat_code_t           status,
  output sle_pkg::pos_t                 position,
  output sle_pkg::count_t               count
);

  sle_pkg::data_t mem [sle_pkg::CAPACITY];
  sle_pkg::data_t rdata;
  sle_pkg::data_t val;
  sle_pkg::req_t  req;
  sle_pkg::cnt_t  lo;
  sle_pkg::cnt_t  hi;
  sle_pkg::cnt_t  cnt;
  sle_pkg::idx_t  ptr;
  sle_pkg::idx_t  mid;
  sle_pkg::idx_t  lo_idx;
  sle_pkg::idx_t  rd_addr;
  logic [sle_pkg::CNT_W:0] mid_sum;
  logic is_ins;

  assign is_ins  = (req == sle_pkg::REQ_INSERT);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[sle_pkg::IDX_W:1];
  assign lo_idx  = lo[sle_pkg::IDX_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      sle_pkg::RD_MID:   rd_addr = mid;
      sle_pkg::RD_LO:    rd_addr = lo_idx;
      sle_pkg::RD_SHIFT: rd_addr = is_ins ? ptr - sle_pkg::idx_t'(1) : ptr + sle_pkg::idx_t'(1);
      default:           rd_addr = mid;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (cmd.wr_shift) begin
      mem[ptr] <= rdata;
    end else if (cmd.wr_val) begin
      mem[lo_idx] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
      val <= value;
      lo  <= '0;
      hi  <= cnt;
    end
    if (cmd.step) begin
      if (rdata < val) begin
        lo <= sle_pkg::cnt_t'(mid) + sle_pkg::cnt_t'(1);
      end else begin
        hi <= sle_pkg::cnt_t'(mid);
      end
    end
    if (cmd.ptr_init) begin
      ptr <= is_ins ? cnt[sle_pkg::IDX_W-1:0] : lo_idx;
    end else if (cmd.wr_shift) begin
      ptr <= is_ins ? ptr - sle_pkg::idx_t'(1) : ptr + sle_pkg::idx_t'(1);
    end
    if (cmd.res_load) begin
      status   <= cmd.res_status;
      position <= cmd.res_pos_lo ? sle_pkg::pos_t'(lo) : '0;
      count    <= sle_pkg::count_t'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.wr_val) begin
      cnt <= cnt + sle_pkg::cnt_t'(1);
    end else if (cmd.dec_count) begin
      cnt <= cnt - sle_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    stat.req         = req;
    stat.full        = (cnt == sle_pkg::cnt_t'(sle_pkg::CAPACITY));
    stat.search_done = (lo >= hi);
    stat.lo_in_range = (lo < cnt);
    stat.match       = (rdata == val);
    stat.shift_end   = is_ins ? (ptr == lo_idx)
                              : (sle_pkg::cnt_t'(ptr) + sle_pkg::cnt_t'(1) == cnt);
  end

endmodule

`default_nettype wire

@@ hw/rtl/sle_ctrl.sv @@
`default_nettype none

module sle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sle_pkg::dp_stat_t stat,
  output sle_pkg::cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CHK_RD,
    S_CHK_CMP,
    S_SH_CHK,
    S_SH_WR,
    S_INS_WR,
    S_RESULT
  } state_t;

  state_t              state;
  sle_pkg::stat_code_t pend_status;
  logic                pend_pos_lo;
  logic                is_ins;
  logic                out_free;

  assign is_ins   = (stat.req == sle_pkg::REQ_INSERT);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      pend_status <= sle_pkg::ST_DONE;
      pend_pos_lo <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (stat.req) inside
            sle_pkg::REQ_INSERT: begin
              if (stat.full) begin
                pend_status <= sle_pkg::ST_FULL;
                pend_pos_lo <= 1'b0;
                state       <= S_RESULT;
              end else begin
                state <= S_SRCH_RD;
              end
            end
            sle_pkg::REQ_REMOVE, sle_pkg::REQ_SEARCH: begin
              state <= S_SRCH_RD;
            end
            default: begin
              pend_status <= sle_pkg::ST_NOT_FOUND;
              pend_pos_lo <= 1'b0;
              state       <= S_RESULT;
            end
          endcase
        end
        S_SRCH_RD: begin
          if (!stat.search_done) begin
            state <= S_SRCH_CMP;
          end else if (is_ins) begin
            state <= S_SH_CHK;
          end else if (stat.lo_in_range) begin
            state <= S_CHK_RD;
          end else begin
            pend_status <= sle_pkg::ST_NOT_FOUND;
            pend_pos_lo <= 1'b0;
            state       <= S_RESULT;
          end
        end
        S_SRCH_CMP: state <= S_SRCH_RD;
        S_CHK_RD:   state <= S_CHK_CMP;
        S_CHK_CMP: begin
          if (!stat.match) begin
            pend_status <= sle_pkg::ST_NOT_FOUND;
            pend_pos_lo <= 1'b0;
            state       <= S_RESULT;
          end else if (stat.req == sle_pkg::REQ_SEARCH) begin
            pend_status <= sle_pkg::ST_DONE;
            pend_pos_lo <= 1'b1;
            state       <= S_RESULT;
          end else begin
            state <= S_SH_CHK;
          end
        end
        S_SH_CHK: begin
          if (!stat.shift_end) begin
            state <= S_SH_WR;
          end else if (is_ins) begin
            state <= S_INS_WR;
          end else begin
            pend_status <= sle_pkg::ST_DONE;
            pend_pos_lo <= 1'b1;
            state       <= S_RESULT;
          end
        end
        S_SH_WR: state <= S_SH_CHK;
        S_INS_WR: begin
          pend_status <= sle_pkg::ST_DONE;
          pend_pos_lo <= 1'b1;
          state       <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = sle_pkg::RD_MID;
    cmd.res_status = pend_status;
    cmd.res_pos_lo = pend_pos_lo;
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_SRCH_RD:  cmd.ptr_init = stat.search_done && is_ins;
      S_SRCH_CMP: cmd.step = 1'b1;
      S_CHK_RD:   cmd.rd_sel = sle_pkg::RD_LO;
      S_CHK_CMP:  cmd.ptr_init = stat.match;
      S_SH_CHK: begin
        cmd.rd_sel    = sle_pkg::RD_SHIFT;
        cmd.dec_count = stat.shift_end && !is_ins;
      end
      S_SH_WR:    cmd.wr_shift = 1'b1;
      S_INS_WR:   cmd.wr_val = 1'b1;
      S_RESULT:   cmd.res_load = out_free;
      default:    cmd.load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_list_engine.sv @@
// One word in flight. A request makes p binary-search probes
// (p <= ceil(log2(count+1))); insert and remove then shift m entries on the
// value memory one at a time, while a full insert or unused kind goes straight
// to the result. The next word can be taken as soon as result valid rises; a
// result still waiting for ready holds back only the next word's result.
// rst (synchronous) empties the store and drops result valid; memory is not cleared.
`default_nettype none

module sorted_list_engine (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            req_type,
  input  wire logic signed [31:0]    value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic [5:0]                 position,
  output logic [6:0]                 count
);

  sle_pkg::cmd_t     cmd;
  sle_pkg::dp_stat_t stat;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sle_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_type (req_type),
    .value    (value),
    .cmd      (cmd),
    .stat     (stat),
    .status   (status),
    .position (position),
    .count    (count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/sle_checker.sv @@
`default_nettype none

module sle_props (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        status,
  input wire logic [5:0]        position,
  input wire logic [6:0]        count
);

  // one word in flight: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back-to-back words");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= 7'(sle_pkg::CAPACITY))
    else $error("count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sle_pkg::ST_FULL |->
      count == 7'(sle_pkg::CAPACITY) && position == '0)
    else $error("full status with room left");

  a_not_found_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sle_pkg::ST_NOT_FOUND |-> position == '0)
    else $error("not-found result with nonzero position");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
      && $stable(count))
    else $error("stalled result changed");

endmodule

bind sorted_list_engine sle_props u_sle_checker (.*);

`default_nettype wire

@@ dv/sle_checker.sv @@
`default_nettype none

module sle_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_ready,
  input  wire logic [1:0]   req_type,
  input  wire logic [31:0]  value,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  wire logic [1:0]   status,
  input  wire logic [5:0]   position,
  input  wire logic [6:0]   count,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    sle_pkg::stat_code_t st;
    sle_pkg::pos_t       pos;
    sle_pkg::count_t     cnt;
  } list_result_t;

  sle_pkg::data_t held_vals [sle_pkg::CAPACITY];
  int             held_num = 0;
  list_result_t   expected_results [$];
  list_result_t   want;
  int             errs = 0;

  // Applies one request to the shadow list; returns the word the block should emit.
  function automatic list_result_t apply_request(sle_pkg::req_t rq, sle_pkg::data_t v);
    list_result_t r;
    int lb;
    int j;
    r.st = sle_pkg::ST_NOT_FOUND;
    r.pos = '0;
    lb = 0;
    while (lb < held_num && held_vals[lb] < v) lb++;
    case (rq) inside
      sle_pkg::REQ_INSERT: begin
        if (held_num >= sle_pkg::CAPACITY) begin
          r.st = sle_pkg::ST_FULL;
        end else begin
          for (j = held_num; j > lb; j--) held_vals[j] = held_vals[j-1];
          held_vals[lb] = v;
          held_num++;
          r.st = sle_pkg::ST_DONE;
          r.pos = sle_pkg::pos_t'(lb);
        end
      end
      sle_pkg::REQ_REMOVE, sle_pkg::REQ_SEARCH: begin
        if (lb < held_num && held_vals[lb] == v) begin
          r.st = sle_pkg::ST_DONE;
          r.pos = sle_pkg::pos_t'(lb);
          if (rq == sle_pkg::REQ_REMOVE) begin
            for (j = lb; j < held_num - 1; j++) held_vals[j] = held_vals[j+1];
            held_num--;
          end
        end
      end
      default: begin
      end
    endcase
    r.cnt = sle_pkg::count_t'(held_num);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_num = 0;
      expected_results.delete();
    end else begin
      // result first: a word leaving this edge belongs to an earlier request
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected word: status=%0d position=%0d count=%0d",
                 status, position, count);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            errs++;
          end
          if (position !== want.pos) begin
            $error("position: expected %0d, actual %0d", want.pos, position);
            errs++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, actual %0d", want.cnt, count);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(sle_pkg::req_t'(req_type),
                                                 sle_pkg::data_t'(value)));
    end
    mismatches <= errs;
    pending <= expected_results.size();
  end

endmodule

`default_nettype wire

@@ dv/tb_sorted_list_engine.sv @@
`default_nettype none

module tb_sorted_list_engine;

  localparam sle_pkg::req_t  REQ_UNUSED = 2'd3;
  localparam sle_pkg::data_t VAL_MIN    = sle_pkg::data_t'(32'h8000_0000);
  localparam sle_pkg::data_t VAL_MAX    = sle_pkg::data_t'(32'h7FFF_FFFF);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sle_pkg::req_t        req_type = sle_pkg::REQ_INSERT;
  sle_pkg::data_t       value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sle_pkg::stat_code_t  status;
  sle_pkg::pos_t        position;
  sle_pkg::count_t      count;

  int          mismatches;
  int          pending;

  int              burst_left = 0;
  sle_pkg::data_t  recent_vals [8];
  int              recent_wr = 0;

  int          rx_mode = 0;
  int          rx_phase_left = 0;
  int          rx_stall_left = 0;

  always #1 clk = ~clk;

  sorted_list_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .position (position),
    .count    (count)
  );

  sle_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position),
    .count     (count),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // result side: always ready, coin flip, or bursty stalls, switching now and then
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_phase_left <= $urandom_range(20, 200);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if (rx_stall_left != 0) begin
            out_ready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall_left <= $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  task automatic send_word(input sle_pkg::req_t rq, input sle_pkg::data_t v);
    int gap;
    in_valid <= 1'b1;
    req_type <= rq;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rq == sle_pkg::REQ_INSERT) begin
      recent_vals[recent_wr] = v;
      recent_wr = (recent_wr + 1) % 8;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  function automatic sle_pkg::data_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return sle_pkg::data_t'($urandom_range(0, 12)) - sle_pkg::data_t'(6);
    if (r < 60) return recent_vals[$urandom_range(0, 7)];
    if (r < 75) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MIN + 1;
        2: return VAL_MAX;
        3: return VAL_MAX - 1;
        4: return '0;
        default: return -1;
      endcase
    end
    return sle_pkg::data_t'($urandom);
  endfunction

  // insert_pct steers the fill level; unused kinds are sprinkled in but not counted
  task automatic run_phase(input int insert_pct, input int n_words);
    int sent;
    int r;
    sle_pkg::req_t rq;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 3) rq = REQ_UNUSED;
      else if (r < insert_pct) rq = sle_pkg::REQ_INSERT;
      else if ($urandom_range(0, 9) < 6) rq = sle_pkg::REQ_REMOVE;
      else rq = sle_pkg::REQ_SEARCH;
      send_word(rq, pick_value());
      if (rq != REQ_UNUSED) sent++;
    end
  endtask

  initial begin
    foreach (recent_vals[i]) recent_vals[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(sle_pkg::REQ_SEARCH, '0);
    send_word(sle_pkg::REQ_REMOVE, sle_pkg::data_t'(5));
    send_word(REQ_UNUSED, sle_pkg::data_t'(7));
    send_word(sle_pkg::REQ_INSERT, '0);
    send_word(sle_pkg::REQ_INSERT, VAL_MAX);
    send_word(sle_pkg::REQ_INSERT, VAL_MIN);
    send_word(sle_pkg::REQ_INSERT, '0);
    send_word(sle_pkg::REQ_INSERT, -1);
    send_word(sle_pkg::REQ_INSERT, sle_pkg::data_t'(1));
    send_word(sle_pkg::REQ_SEARCH, '0);
    send_word(sle_pkg::REQ_SEARCH, VAL_MIN);
    send_word(sle_pkg::REQ_SEARCH, VAL_MAX);
    send_word(sle_pkg::REQ_SEARCH, sle_pkg::data_t'(2));
    send_word(sle_pkg::REQ_REMOVE, '0);
    send_word(sle_pkg::REQ_REMOVE, '0);
    send_word(sle_pkg::REQ_REMOVE, '0);
    send_word(sle_pkg::REQ_REMOVE, VAL_MIN);
    send_word(sle_pkg::REQ_REMOVE, VAL_MAX);
    send_word(sle_pkg::REQ_INSERT, sle_pkg::data_t'(32'h5555_5555));
    send_word(sle_pkg::REQ_INSERT, sle_pkg::data_t'(32'hAAAA_AAAA));
    send_word(REQ_UNUSED, VAL_MAX);
    send_word(sle_pkg::REQ_SEARCH, sle_pkg::data_t'(32'hAAAA_AAAA));

    run_phase(85, 150);
    run_phase(20, 130);
    run_phase(85, 100);
    run_phase(50, 140);
    run_phase(15, 130);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
